/* hdl/hta_pkg.sv */
package hta_pkg;

	// Size of the fixed timer table and field widths.
	localparam int MaxTimers = 6;
	localparam int SlotW     = 3;
	localparam int IdW       = 30;
	localparam int SrcW      = 4;
	localparam int SizeW     = 6;
	localparam int PreW      = 16;
	localparam int IrqW      = 5;

	// Request codes.
	localparam logic [1:0] REQ_ALLOC  = 2'd0;
	localparam logic [1:0] REQ_REFER  = 2'd1;
	localparam logic [1:0] REQ_FREE   = 2'd2;
	localparam logic [1:0] REQ_LOOKUP = 2'd3;

	// Clock source bits.
	localparam logic [SrcW-1:0] SRC_SYS   = 4'b0001;
	localparam logic [SrcW-1:0] SRC_PIX   = 4'b0010;
	localparam logic [SrcW-1:0] SRC_HLINE = 4'b0100;
	localparam logic [SrcW-1:0] SRC_HOLD  = 4'b1000;

	// Timer table, in scan order. The id of a timer is its base shifted right by two.
	localparam logic [31:0] TimerBase [MaxTimers] = '{
		32'hBF801120, 32'hBF8014A0, 32'hBF801490,
		32'hBF801480, 32'hBF801100, 32'hBF801110
	};
	localparam logic [SrcW-1:0] TimerSrc [MaxTimers] = '{
		SRC_SYS, SRC_SYS, SRC_SYS,
		SRC_SYS | SRC_HLINE,
		SRC_SYS | SRC_PIX | SRC_HOLD,
		SRC_SYS | SRC_HLINE | SRC_HOLD
	};
	localparam logic [SizeW-1:0] TimerSize [MaxTimers] = '{
		6'd16, 6'd32, 6'd32, 6'd32, 6'd16, 6'd16
	};
	localparam logic [PreW-1:0] TimerPre [MaxTimers] = '{
		16'd8, 16'd256, 16'd256, 16'd1, 16'd1, 16'd1
	};
	localparam logic [IrqW-1:0] TimerIrq [MaxTimers] = '{
		5'd6, 5'd16, 5'd15, 5'd14, 5'd4, 5'd5
	};

	typedef struct packed {
		logic            status;
		logic [IdW-1:0]  granted_id;
		logic [SlotW-1:0] slot_index;
		logic [IrqW-1:0] irq_line;
	} result_t;

	// Change to the held flags caused by one request.
	typedef struct packed {
		logic             set_en;
		logic             clr_en;
		logic [SlotW-1:0] slot;
	} upd_t;

endpackage

/* hdl/hard_timer_allocator_core.sv */
// Channel   | Handshake          | Payload
// ----------+--------------------+-------------------------------------------------------
// request   | start, busy        | req_type, source_mask, counter_size, min_prescale,
//           |                    | timer_handle
// result    | done (one cycle)   | status, granted_id, slot_index, irq_line
//
// A request is taken on every clock edge where start is high and busy is low, one per cycle.
// It is held in the request register. On the next edge, one pass through the table
// match logic fills the result register, and done is high for the cycle after that edge.
// Reset clears the held flags and both valid bits; busy is set by reset, cleared at the
// next clock edge and low afterward, so requests are stalled only while busy is high.
// The receiver cannot stall; each result is shown for exactly one cycle.

module hard_timer_allocator_core #(
	parameter int NUM_TIMERS = hta_pkg::MaxTimers
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  req_type,
	input  logic [hta_pkg::SrcW-1:0]    source_mask,
	input  logic [hta_pkg::SizeW-1:0]   counter_size,
	input  logic [hta_pkg::PreW-1:0]    min_prescale,
	input  logic [hta_pkg::IdW-1:0]     timer_handle,
	output logic                        done,
	output logic                        status,
	output logic [hta_pkg::IdW-1:0]     granted_id,
	output logic [hta_pkg::SlotW-1:0]   slot_index,
	output logic [hta_pkg::IrqW-1:0]    irq_line
);

	// Request register.
	logic                        valid_s1;
	logic [1:0]                  req_type_s1;
	logic [hta_pkg::SrcW-1:0]    source_mask_s1;
	logic [hta_pkg::SizeW-1:0]   counter_size_s1;
	logic [hta_pkg::PreW-1:0]    min_prescale_s1;
	logic [hta_pkg::IdW-1:0]     timer_handle_s1;

	// One flag per timer: set while the timer is allocated.
	logic [NUM_TIMERS-1:0]       held_q;
	logic                        busy_q;

	// Result register.
	logic                        done_q;
	hta_pkg::result_t            result_q;

	hta_pkg::result_t            result;
	hta_pkg::upd_t               upd;
	logic                        accept;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1     <= req_type;
			source_mask_s1  <= source_mask;
			counter_size_s1 <= counter_size;
			min_prescale_s1 <= min_prescale;
			timer_handle_s1 <= timer_handle;
		end
	end

	// The match sees the held flags as left by the request just before, since those
	// flags update on the same edge that registers that request's result.
	hta_match #(
		.NumTimers (NUM_TIMERS)
	) u_match (
		.req_type     (req_type_s1),
		.source_mask  (source_mask_s1),
		.counter_size (counter_size_s1),
		.min_prescale (min_prescale_s1),
		.timer_handle (timer_handle_s1),
		.held         (held_q),
		.result       (result),
		.upd          (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (valid_s1) begin
			for (int k = 0; k < NUM_TIMERS; k++) begin
				if (upd.slot == hta_pkg::SlotW'(k)) begin
					if (upd.set_en) begin
						held_q[k] <= 1'b1;
					end else if (upd.clr_en) begin
						held_q[k] <= 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= result;
		end
	end

	assign done       = done_q;
	assign status     = result_q.status;
	assign granted_id = result_q.granted_id;
	assign slot_index = result_q.slot_index;
	assign irq_line   = result_q.irq_line;

endmodule

/* hdl/hta_match.sv */
module hta_match #(
	parameter int NumTimers = hta_pkg::MaxTimers
) (
	input  logic [1:0]                  req_type,
	input  logic [hta_pkg::SrcW-1:0]    source_mask,
	input  logic [hta_pkg::SizeW-1:0]   counter_size,
	input  logic [hta_pkg::PreW-1:0]    min_prescale,
	input  logic [hta_pkg::IdW-1:0]     timer_handle,
	input  logic [NumTimers-1:0]        held,
	output hta_pkg::result_t            result,
	output hta_pkg::upd_t               upd
);

	logic [NumTimers-1:0]         alloc_hit;
	logic [NumTimers-1:0]         refer_hit;
	logic [NumTimers-1:0]         id_hit;
	logic                         alloc_found;
	logic                         refer_found;
	logic                         id_found;
	logic [hta_pkg::SlotW-1:0]    alloc_slot;
	logic [hta_pkg::SlotW-1:0]    refer_slot;
	logic [hta_pkg::SlotW-1:0]    id_slot;
	logic [hta_pkg::IdW-1:0]      alloc_id;
	logic [hta_pkg::IdW-1:0]      refer_id;
	logic [hta_pkg::IrqW-1:0]     id_irq;
	logic                         id_held;

	// Per-timer match conditions, all evaluated in parallel.
	always_comb begin
		for (int k = 0; k < NumTimers; k++) begin
			refer_hit[k] = ((source_mask & hta_pkg::TimerSrc[k]) != '0)
				&& (counter_size == hta_pkg::TimerSize[k])
				&& (hta_pkg::TimerPre[k] >= hta_pkg::PreW'(1));
			alloc_hit[k] = ((source_mask & hta_pkg::TimerSrc[k]) != '0)
				&& (counter_size == hta_pkg::TimerSize[k])
				&& (hta_pkg::TimerPre[k] >= min_prescale)
				&& !held[k];
			id_hit[k] = (hta_pkg::TimerBase[k][31:2] == timer_handle);
		end
	end

	// Priority pick: walking from the last slot down leaves the lowest hit.
	always_comb begin
		alloc_found = 1'b0;
		refer_found = 1'b0;
		id_found    = 1'b0;
		alloc_slot  = '0;
		refer_slot  = '0;
		id_slot     = '0;
		alloc_id    = '0;
		refer_id    = '0;
		id_irq      = '0;
		id_held     = 1'b0;
		for (int k = NumTimers - 1; k >= 0; k--) begin
			if (alloc_hit[k]) begin
				alloc_found = 1'b1;
				alloc_slot  = hta_pkg::SlotW'(k);
				alloc_id    = hta_pkg::TimerBase[k][31:2];
			end
			if (refer_hit[k]) begin
				refer_found = 1'b1;
				refer_slot  = hta_pkg::SlotW'(k);
				refer_id    = hta_pkg::TimerBase[k][31:2];
			end
			if (id_hit[k]) begin
				id_found = 1'b1;
				id_slot  = hta_pkg::SlotW'(k);
				id_irq   = hta_pkg::TimerIrq[k];
				id_held  = held[k];
			end
		end
	end

	always_comb begin
		result = '{status: 1'b1, granted_id: '0, slot_index: '0, irq_line: '0};
		upd    = '{set_en: 1'b0, clr_en: 1'b0, slot: '0};
		unique case (req_type)
			hta_pkg::REQ_ALLOC: begin
				if (alloc_found) begin
					result.status     = 1'b0;
					result.granted_id = alloc_id;
					result.slot_index = alloc_slot;
					upd.set_en        = 1'b1;
					upd.slot          = alloc_slot;
				end
			end
			hta_pkg::REQ_REFER: begin
				if (refer_found) begin
					result.status     = 1'b0;
					result.granted_id = refer_id;
					result.slot_index = refer_slot;
				end
			end
			hta_pkg::REQ_FREE: begin
				if (id_found && id_held) begin
					result.status     = 1'b0;
					result.slot_index = id_slot;
					upd.clr_en        = 1'b1;
					upd.slot          = id_slot;
				end
			end
			hta_pkg::REQ_LOOKUP: begin
				if (id_found) begin
					result.status     = 1'b0;
					result.slot_index = id_slot;
					result.irq_line   = id_irq;
				end
			end
			default: begin
				result.status = 1'b1;
			end
		endcase
	end

endmodule
